FILE: rtl/prq_pkg.sv
// prq_pkg: shared types, codes and sizes for the priority ready queue
// no dependencies; imported by every module of the block

package prq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int PRIO_BITS   = 8;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// stored widths: port fields are 16 and 8 bits, narrowed further by the sizes above
	localparam int SID_W   = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int SPRIO_W = (PRIO_BITS < 8) ? PRIO_BITS : 8;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;
	localparam logic [1:0] FUNC_LOOKUP = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] proc_id;
		logic [7:0]  proc_priority;
	} prq_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_id;
		logic [7:0]  out_priority;
		logic [4:0]  occupancy;
	} prq_rsp_t;

	typedef struct packed {
		logic [SID_W-1:0]   id;
		logic [SPRIO_W-1:0] prio;
	} prq_entry_t;

	typedef struct packed {
		logic prio_lt;
		logic id_eq;
	} prq_flags_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_FIND,
		S_SHIFT,
		S_DONE
	} prq_state_t;

endpackage

FILE: rtl/prq_store.sv
// prq_store: entry array in queue order, one write port and one read port
// depends on prq_pkg

module prq_store
	import prq_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  prq_entry_t       wdata,
	input  logic [IDX_W-1:0] raddr,
	output prq_entry_t       rdata
);

	prq_entry_t slot_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			slot_q[waddr] <= wdata;
		end
	end

	assign rdata = slot_q[raddr];

endmodule

FILE: rtl/prq_cmp.sv
// prq_cmp: shared compare unit, checks one stored entry against the key
// depends on prq_pkg

module prq_cmp
	import prq_pkg::*;
(
	input  prq_entry_t entry,
	input  prq_entry_t key,
	output prq_flags_t flags
);

	assign flags.prio_lt = entry.prio < key.prio;
	assign flags.id_eq   = entry.id == key.id;

endmodule

FILE: rtl/priority_ready_queue.sv
// priority_ready_queue: stable priority queue of process entries with a slot-walking sequencer
// depends on prq_pkg, prq_store, prq_cmp
// insert walks from the tail and moves each lower-ranked entry back one slot, then writes the new one
// (refused when full); pop/remove find the front slot or the matching id and close the gap behind it;
// lookup scans until the match or the end of the queue; the walks cover one slot per cycle
// throughput: one item at a time, busy stays high until done; the store's single read port sets the pace
// reset (arst_n low) empties the queue and idles the sequencer; done pulses once per item

module priority_ready_queue
	import prq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  prq_cmd_t cmd,
	output logic     busy,
	output logic     done,
	output prq_rsp_t rsp
);

	prq_state_t state_q, state_d;

	logic [1:0]       func_q;
	prq_entry_t       key_q;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] nxt_idx;
	prq_rsp_t         res_q, res_d;

	logic             we;
	logic [IDX_W-1:0] waddr;
	prq_entry_t       wdata;
	logic [IDX_W-1:0] raddr;
	prq_entry_t       rdata;
	prq_flags_t       flags;

	logic accept;
	logic full;
	logic shift_ins;
	logic scan_end;
	logic find_hit;
	logic shift_more;

	// entry storage and the one compare unit that the insert and search walks go through
	prq_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	prq_cmp u_cmp (
		.entry (rdata),
		.key   (key_q),
		.flags (flags)
	);

	assign accept     = start && (state_q == S_IDLE);
	assign nxt_idx    = idx_q + CNT_W'(1);
	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	// insert walks from the tail: move an entry back while it ranks below the new one
	assign shift_ins  = (idx_q != '0) && flags.prio_lt;
	assign scan_end   = idx_q >= cnt_q;
	// pop is a remove of the front slot
	assign find_hit   = (func_q == FUNC_POP) || flags.id_eq;
	assign shift_more = nxt_idx < cnt_q;

	// read address per phase: slot ahead of the hole, scanned slot, or slot behind the gap
	always_comb begin
		case (state_q)
			S_INS:   raddr = IDX_W'(idx_q - CNT_W'(1));
			S_SHIFT: raddr = nxt_idx[IDX_W-1:0];
			default: raddr = idx_q[IDX_W-1:0];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cmd.func == FUNC_INSERT) ? S_INS : S_FIND;
				end
			end
			S_INS: begin
				if (full || !shift_ins) begin
					state_d = S_DONE;
				end
			end
			S_FIND: begin
				if (scan_end) begin
					state_d = S_DONE;
				end else if (find_hit) begin
					state_d = (func_q == FUNC_LOOKUP) ? S_DONE : S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (!shift_more) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// datapath control and result assembly
	always_comb begin
		idx_d = idx_q;
		cnt_d = cnt_q;
		res_d = res_q;
		we    = 1'b0;
		waddr = idx_q[IDX_W-1:0];
		wdata = rdata;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					idx_d = (cmd.func == FUNC_INSERT) ? cnt_q : '0;
				end
			end
			S_INS: begin
				if (full) begin
					res_d = '{status: ST_FULL, out_id: '0, out_priority: '0,
					          occupancy: 5'(cnt_q)};
				end else if (shift_ins) begin
					// open the hole one slot further forward
					we    = 1'b1;
					idx_d = idx_q - CNT_W'(1);
				end else begin
					we    = 1'b1;
					wdata = key_q;
					cnt_d = cnt_q + CNT_W'(1);
					res_d = '{status: ST_OK, out_id: '0, out_priority: '0,
					          occupancy: 5'(cnt_q + CNT_W'(1))};
				end
			end
			S_FIND: begin
				if (scan_end) begin
					res_d = '{status: (func_q == FUNC_POP) ? ST_EMPTY : ST_NOT_FOUND,
					          out_id: '0, out_priority: '0, occupancy: 5'(cnt_q)};
				end else if (find_hit) begin
					res_d = '{status: ST_OK, out_id: 16'(rdata.id),
					          out_priority: 8'(rdata.prio), occupancy: 5'(cnt_q)};
				end else begin
					idx_d = nxt_idx;
				end
			end
			S_SHIFT: begin
				if (shift_more) begin
					// close the gap one slot at a time
					we    = 1'b1;
					idx_d = nxt_idx;
				end else begin
					cnt_d           = cnt_q - CNT_W'(1);
					res_d.occupancy = 5'(cnt_q - CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// payload registers: command key, walk index and result
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= cmd.func;
			key_q   <= '{id: SID_W'(cmd.proc_id), prio: SPRIO_W'(cmd.proc_priority)};
		end
		idx_q <= idx_d;
		res_q <= res_d;
	end

	// outputs
	always_comb begin
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
		rsp  = res_q;
	end

	// an accepted item keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not start the sequencer");

	// the result strobe ends the item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer still busy after result");

	// refused or missed operations carry no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.out_id == '0 && rsp.out_priority == '0))
		else $error("failed operation returned entry data");

	// full refusal only when the queue really is full
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> (rsp.occupancy == 5'(QUEUE_DEPTH)))
		else $error("full status with spare room");

	// occupancy reported matches the stored count
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.occupancy == 5'(cnt_q)))
		else $error("reported occupancy differs from entry count");

endmodule
